FILE: rtl/cagm_pkg.sv
`default_nettype none

package cagm_pkg;

  // Width of one gradient sample.
  localparam int unsigned SampleBits = 16;

  // A squared magnitude needs one bit less than twice the sample width.
  localparam int unsigned SqBits = 2 * SampleBits - 1;
  // The sum of two squares needs twice the sample width.
  localparam int unsigned RadBits = 2 * SampleBits;
  // The square root remainder stays below twice the root plus one.
  localparam int unsigned RemBits = SampleBits + 2;
  // One root bit is resolved per cell.
  localparam int unsigned NumCells = SampleBits;

  // One input beat: one channel of one pixel.
  typedef struct packed {
    logic signed [SampleBits-1:0] grad_x;
    logic signed [SampleBits-1:0] grad_y;
    logic                         last_channel;
  } cagm_in_t;

  // One output beat: one pixel.
  typedef struct packed {
    logic signed [SampleBits-1:0] best_x;
    logic signed [SampleBits-1:0] best_y;
    logic        [SampleBits-1:0] magnitude;
  } cagm_out_t;

  // Data handed from one root cell to the next.
  typedef struct packed {
    logic                         valid;
    logic signed [SampleBits-1:0] best_x;
    logic signed [SampleBits-1:0] best_y;
    logic        [RadBits-1:0]    rad;
    logic        [RemBits-1:0]    rem;
    logic        [SampleBits-1:0] root;
  } cagm_cell_t;

  // Unsigned magnitude of a two's complement sample; the most negative
  // value maps to 2^(SampleBits-1), which still fits.
  function automatic logic [SampleBits-1:0] mag_of(logic [SampleBits-1:0] v);
    return v[SampleBits-1] ? ((~v) + SampleBits'(1)) : v;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/channel_absmax_gradient_magnitude_top.sv
// An item with last_channel set is registered through the pick, square and sum
// stages, then through one cell of the square root chain per root bit.
// Throughput: one channel beat per cycle; the whole pipeline advances as one and
// holds only while a result waits at the output under stall.
// Reset clears the pixel state, the kept samples and every stage's valid bit.
`default_nettype none

module channel_absmax_gradient_magnitude_top import cagm_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire cagm_in_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output cagm_out_t      out_data_o
);

  logic       en;
  cagm_cell_t chain [NumCells+1];

  // The pipeline moves whenever the output slot is empty or being taken.
  assign en         = !(chain[NumCells].valid && out_stall_i);
  assign in_stall_o = !en;

  cagm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .cell_o     (chain[0])
  );

  // Row of root cells, one result bit each.
  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    cagm_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .cell_i (chain[i]),
      .cell_o (chain[i+1])
    );
  end

  // Output beat.
  assign out_valid_o          = chain[NumCells].valid;
  assign out_data_o.best_x    = chain[NumCells].best_x;
  assign out_data_o.best_y    = chain[NumCells].best_y;
  assign out_data_o.magnitude = chain[NumCells].root;

endmodule

`default_nettype wire

FILE: rtl/cagm_front.sv
`default_nettype none

module cagm_front import cagm_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       en_i,
  input  wire logic       in_valid_i,
  input  wire cagm_in_t   in_data_i,
  output cagm_cell_t      cell_o
);

  logic                         accept;
  logic                         pixel_open_q, pixel_open_d;
  logic signed [SampleBits-1:0] kept_x_q, kept_y_q;
  logic signed [SampleBits-1:0] pick_x, pick_y;

  // Pick stage registers.
  logic                         p_valid_q;
  logic signed [SampleBits-1:0] p_x_q, p_y_q;
  logic        [SampleBits-1:0] p_ax_q, p_ay_q;

  // Square stage registers.
  logic                         s_valid_q;
  logic signed [SampleBits-1:0] s_x_q, s_y_q;
  logic        [SqBits-1:0]     s_sqx_q, s_sqy_q;

  // Sum stage registers.
  logic                         r_valid_q;
  logic signed [SampleBits-1:0] r_x_q, r_y_q;
  logic        [RadBits-1:0]    r_rad_q;

  logic        [RadBits-1:0]    prod_x, prod_y;

  assign accept = in_valid_i && en_i;

  // The first channel of a pixel is taken as is; later channels replace
  // the kept sample unless the kept one is strictly larger in magnitude.
  always_comb begin
    if (!pixel_open_q) begin
      pick_x = in_data_i.grad_x;
      pick_y = in_data_i.grad_y;
    end else begin
      pick_x = (mag_of(kept_x_q) > mag_of(in_data_i.grad_x)) ? kept_x_q
                                                              : in_data_i.grad_x;
      pick_y = (mag_of(kept_y_q) > mag_of(in_data_i.grad_y)) ? kept_y_q
                                                              : in_data_i.grad_y;
    end
  end

  assign pixel_open_d = accept ? !in_data_i.last_channel : pixel_open_q;

  // Pixel state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_open_q <= 1'b0;
      kept_x_q     <= '0;
      kept_y_q     <= '0;
    end else begin
      pixel_open_q <= pixel_open_d;
      if (accept) begin
        kept_x_q <= pick_x;
        kept_y_q <= pick_y;
      end
    end
  end

  // Unsigned squares of the magnitudes.
  assign prod_x = {{SampleBits{1'b0}}, p_ax_q} * {{SampleBits{1'b0}}, p_ax_q};
  assign prod_y = {{SampleBits{1'b0}}, p_ay_q} * {{SampleBits{1'b0}}, p_ay_q};

  // Valid bits of the three front stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      s_valid_q <= 1'b0;
      r_valid_q <= 1'b0;
    end else if (en_i) begin
      p_valid_q <= accept && in_data_i.last_channel;
      s_valid_q <= p_valid_q;
      r_valid_q <= s_valid_q;
    end
  end

  // Payload of the three front stages.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_x_q   <= pick_x;
      p_y_q   <= pick_y;
      p_ax_q  <= mag_of(pick_x);
      p_ay_q  <= mag_of(pick_y);
      s_x_q   <= p_x_q;
      s_y_q   <= p_y_q;
      s_sqx_q <= prod_x[SqBits-1:0];
      s_sqy_q <= prod_y[SqBits-1:0];
      r_x_q   <= s_x_q;
      r_y_q   <= s_y_q;
      r_rad_q <= {1'b0, s_sqx_q} + {1'b0, s_sqy_q};
    end
  end

  // Seed of the root chain.
  always_comb begin
    cell_o.valid  = r_valid_q;
    cell_o.best_x = r_x_q;
    cell_o.best_y = r_y_q;
    cell_o.rad    = r_rad_q;
    cell_o.rem    = '0;
    cell_o.root   = '0;
  end

endmodule

`default_nettype wire

FILE: rtl/cagm_sqrt_cell.sv
`default_nettype none

module cagm_sqrt_cell import cagm_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       en_i,
  input  wire cagm_cell_t cell_i,
  output cagm_cell_t      cell_o
);

  logic                  valid_q;
  cagm_cell_t            data_q;
  logic [RemBits+1:0]    rem_sh;
  logic [RemBits+1:0]    trial;
  logic [RemBits+1:0]    diff;
  logic                  fits;
  cagm_cell_t            data_d;

  // One restoring step: bring down the next two radicand bits and try
  // to subtract four times the root plus one.
  always_comb begin
    rem_sh = {cell_i.rem, cell_i.rad[RadBits-1 -: 2]};
    trial  = {2'b00, cell_i.root, 2'b01};
    diff   = rem_sh - trial;
    fits   = (rem_sh >= trial);

    data_d        = cell_i;
    data_d.rad    = {cell_i.rad[RadBits-3:0], 2'b00};
    data_d.rem    = fits ? diff[RemBits-1:0] : rem_sh[RemBits-1:0];
    data_d.root   = {cell_i.root[SampleBits-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= cell_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  always_comb begin
    cell_o       = data_q;
    cell_o.valid = valid_q;
  end

endmodule

`default_nettype wire

FILE: rtl/cagm_checker.sv
`default_nettype none

module cagm_checker import cagm_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_stall_o,
  input wire cagm_in_t  in_data_i,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire cagm_out_t out_data_o
);

  logic signed [63:0] bx_l, by_l;
  logic        [63:0] sum_sq, m_l, m_sq, m1_sq;

  assign bx_l   = 64'(out_data_o.best_x);
  assign by_l   = 64'(out_data_o.best_y);
  assign sum_sq = 64'(bx_l * bx_l + by_l * by_l);
  assign m_l    = 64'(out_data_o.magnitude);
  assign m_sq   = m_l * m_l;
  assign m1_sq  = (m_l + 64'd1) * (m_l + 64'd1);

  // A held result keeps its beat.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");

  // The input is held back exactly when a finished result is blocked.
  a_stall_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall does not follow the output slot");

  // The magnitude is the floor root of the sum of squares.
  a_root_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> m_sq <= sum_sq)
    else $error("magnitude too large");

  a_root_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> sum_sq < m1_sq)
    else $error("magnitude too small");

  // Nothing comes out in the cycle after reset releases.
  a_reset_quiet: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

  logic unused_in;
  assign unused_in = in_valid_i ^ (^in_data_i);

endmodule

bind channel_absmax_gradient_magnitude_top cagm_checker u_cagm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
